>>> rtl/twrsm_pkg.sv
package twrsm_pkg;

    localparam int unsigned TickW = 10;
    localparam int unsigned FrameBits = 16;
    localparam int unsigned ReadBits = 12;
    localparam int unsigned BitIdxW = 5;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [1:0] ACT_PLAIN = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS = 2'd1;

    localparam logic [TickW-1:0] PHASE_TICKS_RST  = 10'd2;
    localparam logic [TickW-1:0] SETTLE_TICKS_RST = 10'd10;

    localparam logic [BitIdxW-1:0] WR_FIRST_BIT = 5'd15;
    localparam logic [BitIdxW-1:0] RA_FIRST_BIT = 5'd4;
    localparam logic [BitIdxW-1:0] RD_FIRST_BIT = 5'd11;
    localparam logic [BitIdxW-1:0] RD_LIMIT     = 5'd12;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  reg_addr;
        logic [11:0] write_data;
        logic        data_in;
    } t_in_item;

    typedef struct packed {
        logic        pin_data;
        logic        pin_clock;
        logic        pin_latch_enable;
        logic        pin_read_mode;
        logic        data_pin_driven;
        logic        busy_res;
        logic        read_valid;
        logic [11:0] read_value;
    } t_out_item;

endpackage

>>> rtl/three_wire_rf_serial_master.sv
// Channel   Direction  Handshake               Payload
// in        request    i_in_valid / o_in_stall  t_in_item  (one tick)
// out       result     o_out_valid / i_out_stall t_out_item (pins after the tick)
// cfg       write      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request is taken every cycle while the input is not stalled; its result is
// registered and shows in the next cycle. The sequencer state, hold counter and result
// register update in the same cycle. A stalled result holds and stalls the input; a
// request is still taken when the waiting result is taken in the same cycle.
// Synchronous active-low reset returns the sequencer to idle with the default tick counts.
module three_wire_rf_serial_master
    import twrsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [TickW-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_W_PRE   = 5'd1,
        ST_W_LE1   = 5'd2,
        ST_W_LE0   = 5'd3,
        ST_W_BIT0  = 5'd4,
        ST_W_BIT1  = 5'd5,
        ST_W_BIT2  = 5'd6,
        ST_W_POST  = 5'd7,
        ST_W_TAIL  = 5'd8,
        ST_R_LE1   = 5'd9,
        ST_R_LE0   = 5'd10,
        ST_R_ADDR0 = 5'd11,
        ST_R_ADDR1 = 5'd12,
        ST_R_ADDR2 = 5'd13,
        ST_R_TURN0 = 5'd14,
        ST_R_TURN1 = 5'd15,
        ST_R_TURN2 = 5'd16,
        ST_R_DATA0 = 5'd17,
        ST_R_DATA1 = 5'd18,
        ST_R_DATA2 = 5'd19,
        ST_R_DATA3 = 5'd20,
        ST_R_DATA4 = 5'd21,
        ST_R_END   = 5'd22
    } t_step;

    t_step                r_step, n_step;
    logic [TickW-1:0]     r_hold, n_hold;
    logic [BitIdxW-1:0]   r_bit, n_bit;
    logic [FrameBits-1:0] r_frame, n_frame;
    logic [ReadBits-1:0]  r_accum, n_accum;
    logic [TickW-1:0]     r_phase_ticks;
    logic [TickW-1:0]     r_settle_ticks;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;
    logic                 n_done;
    logic                 in_accept;
    logic [TickW-1:0]     dur_cur;
    logic [TickW-1:0]     dur_next;
    logic [TickW:0]       hold_inc;
    logic                 frame_bit;
    logic                 clk_w;
    logic                 clk_r;

    function automatic logic [TickW-1:0] step_dur(input t_step s,
                                                  input logic [TickW-1:0] phase,
                                                  input logic [TickW-1:0] settle);
        logic [TickW-1:0] d;
        if (s == ST_W_PRE || s == ST_W_LE0 || s == ST_W_POST ||
            s == ST_R_LE1 || s == ST_R_LE0) begin
            d = settle;
        end else begin
            d = phase;
        end
        if (d == '0) begin
            d = TickW'(1);
        end
        return d;
    endfunction

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign dur_cur  = step_dur(r_step, r_phase_ticks, r_settle_ticks);
    assign dur_next = step_dur(n_step, r_phase_ticks, r_settle_ticks);
    assign hold_inc = {1'b0, r_hold} + (TickW+1)'(1);

    always_comb begin
        n_step  = r_step;
        n_hold  = r_hold;
        n_bit   = r_bit;
        n_frame = r_frame;
        n_accum = r_accum;
        n_done  = 1'b0;
        if (r_step != ST_IDLE) begin
            if (hold_inc >= {1'b0, dur_cur}) begin
                n_hold = '0;
                unique case (r_step)
                    ST_W_LE0: begin
                        n_step = ST_W_BIT0;
                        n_bit  = WR_FIRST_BIT;
                    end
                    ST_W_BIT2: begin
                        if (r_bit == '0) begin
                            n_step = ST_W_POST;
                        end else begin
                            n_bit  = r_bit - BitIdxW'(1);
                            n_step = ST_W_BIT0;
                        end
                    end
                    ST_R_LE0: begin
                        n_step = ST_R_ADDR0;
                        n_bit  = RA_FIRST_BIT;
                    end
                    ST_R_ADDR2: begin
                        if (r_bit == '0) begin
                            n_step = ST_R_TURN0;
                        end else begin
                            n_bit  = r_bit - BitIdxW'(1);
                            n_step = ST_R_ADDR0;
                        end
                    end
                    ST_R_TURN2: begin
                        n_step = ST_R_DATA0;
                        n_bit  = RD_FIRST_BIT;
                    end
                    ST_R_DATA4: begin
                        if (r_bit == '0) begin
                            n_step = ST_R_END;
                        end else begin
                            n_bit  = r_bit - BitIdxW'(1);
                            n_step = ST_R_DATA0;
                        end
                    end
                    ST_R_END: begin
                        n_step = ST_IDLE;
                        n_done = 1'b1;
                    end
                    ST_W_PRE, ST_W_LE1, ST_W_BIT0, ST_W_BIT1, ST_W_POST,
                    ST_R_LE1, ST_R_ADDR0, ST_R_ADDR1, ST_R_TURN0, ST_R_TURN1,
                    ST_R_DATA0, ST_R_DATA1, ST_R_DATA2, ST_R_DATA3: begin
                        n_step = t_step'(r_step + 5'd1);
                    end
                    default: begin
                        n_step = ST_IDLE;
                    end
                endcase
            end else begin
                n_hold = hold_inc[TickW-1:0];
            end
        end else if (i_in_data.action == ACT_WRITE) begin
            n_frame = {i_in_data.write_data, i_in_data.reg_addr[3:0]};
            n_step  = ST_W_PRE;
            n_hold  = '0;
        end else if (i_in_data.action == ACT_READ) begin
            n_frame = FrameBits'(i_in_data.reg_addr);
            n_accum = '0;
            n_step  = ST_R_LE1;
            n_hold  = '0;
        end

        if (n_step == ST_R_DATA3 &&
            ({1'b0, n_hold} + (TickW+1)'(1)) >= {1'b0, dur_next} &&
            i_in_data.data_in && n_bit < RD_LIMIT) begin
            n_accum[n_bit[3:0]] = 1'b1;
        end
    end

    always_comb begin
        frame_bit = n_bit[4] ? 1'b0 : n_frame[n_bit[3:0]];
        clk_w = 1'b0;
        clk_r = 1'b0;
        unique case (n_step)
            ST_W_BIT0:  clk_w = ~n_bit[0];
            ST_W_BIT1:  clk_w = 1'b1;
            ST_W_BIT2:  clk_w = n_bit[0];
            ST_R_ADDR0: clk_r = n_bit[0];
            ST_R_ADDR1: clk_r = 1'b1;
            ST_R_ADDR2: clk_r = ~n_bit[0];
            default: begin
                clk_w = 1'b0;
                clk_r = 1'b0;
            end
        endcase

        n_out = '0;
        n_out.busy_res        = (n_step != ST_IDLE);
        n_out.read_valid      = n_done;
        n_out.read_value      = n_accum;
        n_out.data_pin_driven = ~(n_step >= ST_R_TURN0 && n_step <= ST_R_END);
        unique case (n_step)
            ST_W_BIT0, ST_W_BIT1, ST_W_BIT2: begin
                n_out.pin_data  = frame_bit;
                n_out.pin_clock = clk_w;
            end
            ST_R_ADDR0, ST_R_ADDR1, ST_R_ADDR2: begin
                n_out.pin_data  = frame_bit;
                n_out.pin_clock = clk_r;
            end
            ST_W_LE1, ST_W_POST, ST_W_TAIL, ST_R_LE1: begin
                n_out.pin_latch_enable = 1'b1;
            end
            ST_R_TURN0, ST_R_DATA1, ST_R_DATA2, ST_R_DATA3: begin
                n_out.pin_read_mode = 1'b1;
                n_out.pin_clock     = 1'b1;
            end
            ST_R_TURN1, ST_R_TURN2, ST_R_DATA0, ST_R_DATA4: begin
                n_out.pin_read_mode = 1'b1;
            end
            ST_R_END: begin
                n_out.pin_read_mode    = 1'b1;
                n_out.pin_latch_enable = 1'b1;
            end
            default: begin
                n_out.pin_data = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= ST_IDLE;
            r_hold         <= '0;
            r_bit          <= '0;
            r_frame        <= '0;
            r_accum        <= '0;
            r_phase_ticks  <= PHASE_TICKS_RST;
            r_settle_ticks <= SETTLE_TICKS_RST;
            r_out_valid    <= 1'b0;
            r_out          <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PHASE_TICKS) begin
                    r_phase_ticks <= i_cfg_data;
                end else if (i_cfg_index == CFG_SETTLE_TICKS) begin
                    r_settle_ticks <= i_cfg_data;
                end
            end
            if (in_accept) begin
                r_step      <= n_step;
                r_hold      <= n_hold;
                r_bit       <= n_bit;
                r_frame     <= n_frame;
                r_accum     <= n_accum;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/twrsm_checker.sv
module twrsm_checker
    import twrsm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A finished read has already returned the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_valid |-> !o_out_data.busy_res)
        else $error("read completion while busy");

    // During read-back the data pin is released and read mode is high.
    a_turnaround: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.data_pin_driven |->
            !o_out_data.pin_data && o_out_data.pin_read_mode)
        else $error("data pin driven during read-back");

    // In idle every pin is low.
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.busy_res |->
            !o_out_data.pin_data && !o_out_data.pin_clock &&
            !o_out_data.pin_latch_enable && !o_out_data.pin_read_mode &&
            o_out_data.data_pin_driven)
        else $error("pins active while idle");

endmodule

bind three_wire_rf_serial_master twrsm_checker u_twrsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> sim/three_wire_rf_serial_master_tb.sv
module three_wire_rf_serial_master_tb;
    import twrsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int DIN_LOW    = 0;
    localparam int DIN_HIGH   = 1;
    localparam int DIN_RANDOM = 2;

    localparam logic [6:0] SEQ_IDLE    = 7'd0;
    localparam logic [6:0] SEQ_WR_PRE  = 7'd1;
    localparam logic [6:0] SEQ_WR_LE1  = 7'd2;
    localparam logic [6:0] SEQ_WR_LE0  = 7'd3;
    localparam logic [6:0] SEQ_WR_BIT  = 7'd4;
    localparam logic [6:0] SEQ_WR_POST = 7'd7;
    localparam logic [6:0] SEQ_WR_TAIL = 7'd8;
    localparam logic [6:0] SEQ_RD_LE1  = 7'd9;
    localparam logic [6:0] SEQ_RD_LE0  = 7'd10;
    localparam logic [6:0] SEQ_RD_ADDR = 7'd11;
    localparam logic [6:0] SEQ_RD_TURN = 7'd14;
    localparam logic [6:0] SEQ_RD_BIT  = 7'd17;
    localparam logic [6:0] SEQ_RD_END  = 7'd22;

    class pin_scoreboard;
        logic [TickW-1:0] phase_len = PHASE_TICKS_RST;
        logic [TickW-1:0] settle_len = SETTLE_TICKS_RST;
        logic [6:0] seq_state = SEQ_IDLE;
        logic [TickW-1:0] held = '0;
        logic [BitIdxW-1:0] bit_pos = '0;
        logic [15:0] frame_bits = '0;
        logic [11:0] rd_value = '0;
        t_out_item expected_pins[$];
        int errors = 0;

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
            if (idx == CFG_PHASE_TICKS) begin
                phase_len = val;
            end else if (idx == CFG_SETTLE_TICKS) begin
                settle_len = val;
            end
        endfunction

        function logic busy();
            return seq_state != SEQ_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function logic [TickW-1:0] hold_len(logic [6:0] st);
            logic [TickW-1:0] d;
            if (st == SEQ_WR_PRE || st == SEQ_WR_LE0 || st == SEQ_WR_POST ||
                st == SEQ_RD_LE1 || st == SEQ_RD_LE0) begin
                d = settle_len;
            end else begin
                d = phase_len;
            end
            return (d == 0) ? 10'd1 : d;
        endfunction

        function logic out_bit();
            return (bit_pos >= FrameBits) ? 1'b0 : frame_bits[bit_pos[3:0]];
        endfunction

        // Returns {read mode, latch enable, clock, data}.
        function logic [3:0] pin_levels();
            logic odd;
            logic [6:0] sub;
            logic clk_level;
            odd = bit_pos[0];
            if (seq_state >= SEQ_WR_BIT && seq_state < SEQ_WR_BIT + 3) begin
                sub = seq_state - SEQ_WR_BIT;
                clk_level = odd ? (sub != 0) : (sub != 2);
                return {2'b00, clk_level, out_bit()};
            end
            if (seq_state >= SEQ_RD_ADDR && seq_state < SEQ_RD_ADDR + 3) begin
                sub = seq_state - SEQ_RD_ADDR;
                clk_level = odd ? (sub != 2) : (sub != 0);
                return {2'b00, clk_level, out_bit()};
            end
            case (seq_state)
                SEQ_WR_LE1, SEQ_WR_POST, SEQ_WR_TAIL, SEQ_RD_LE1: return 4'b0100;
                SEQ_RD_TURN, SEQ_RD_BIT + 1, SEQ_RD_BIT + 2, SEQ_RD_BIT + 3: return 4'b1010;
                SEQ_RD_TURN + 1, SEQ_RD_TURN + 2, SEQ_RD_BIT, SEQ_RD_BIT + 4: return 4'b1000;
                SEQ_RD_END: return 4'b1100;
                default: return 4'b0000;
            endcase
        endfunction

        // Moves the sequencer on; returns 1 when a read finishes.
        function logic next_state();
            logic read_done;
            read_done = 1'b0;
            case (seq_state)
                SEQ_WR_LE0: begin
                    seq_state = SEQ_WR_BIT;
                    bit_pos = WR_FIRST_BIT;
                end
                SEQ_WR_BIT + 2: begin
                    if (bit_pos == 0) begin
                        seq_state = SEQ_WR_POST;
                    end else begin
                        bit_pos--;
                        seq_state = SEQ_WR_BIT;
                    end
                end
                SEQ_WR_TAIL: seq_state = SEQ_IDLE;
                SEQ_RD_LE0: begin
                    seq_state = SEQ_RD_ADDR;
                    bit_pos = RA_FIRST_BIT;
                end
                SEQ_RD_ADDR + 2: begin
                    if (bit_pos == 0) begin
                        seq_state = SEQ_RD_TURN;
                    end else begin
                        bit_pos--;
                        seq_state = SEQ_RD_ADDR;
                    end
                end
                SEQ_RD_TURN + 2: begin
                    seq_state = SEQ_RD_BIT;
                    bit_pos = RD_FIRST_BIT;
                end
                SEQ_RD_BIT + 4: begin
                    if (bit_pos == 0) begin
                        seq_state = SEQ_RD_END;
                    end else begin
                        bit_pos--;
                        seq_state = SEQ_RD_BIT;
                    end
                end
                SEQ_RD_END: begin
                    seq_state = SEQ_IDLE;
                    read_done = 1'b1;
                end
                default: begin
                    if (seq_state != SEQ_IDLE && seq_state < SEQ_RD_END) begin
                        seq_state = seq_state + 7'd1;
                    end else begin
                        seq_state = SEQ_IDLE;
                    end
                end
            endcase
            return read_done;
        endfunction

        function void note_tick(t_in_item it);
            t_out_item want;
            logic done;
            logic driven;
            logic [3:0] pins;
            done = 1'b0;
            if (seq_state != SEQ_IDLE) begin
                held++;
                if (held >= hold_len(seq_state)) begin
                    held = '0;
                    done = next_state();
                end
            end else if (it.action == ACT_WRITE) begin
                frame_bits = {it.write_data, it.reg_addr[3:0]};
                seq_state = SEQ_WR_PRE;
                held = '0;
            end else if (it.action == ACT_READ) begin
                frame_bits = {11'd0, it.reg_addr};
                rd_value = '0;
                seq_state = SEQ_RD_LE1;
                held = '0;
            end

            // The data pin is sampled on the last tick of the last clock-high state of each read bit.
            if (seq_state == SEQ_RD_BIT + 3 && int'(held) + 1 >= int'(hold_len(seq_state)) &&
                it.data_in && bit_pos < RD_LIMIT) begin
                rd_value[bit_pos] = 1'b1;
            end

            pins = pin_levels();
            driven = !(seq_state >= SEQ_RD_TURN && seq_state <= SEQ_RD_END);
            if (!driven) begin
                pins[0] = 1'b0;
            end
            want.pin_data = pins[0];
            want.pin_clock = pins[1];
            want.pin_latch_enable = pins[2];
            want.pin_read_mode = pins[3];
            want.data_pin_driven = driven;
            want.busy_res = (seq_state != SEQ_IDLE);
            want.read_valid = done;
            want.read_value = rd_value;
            expected_pins.push_back(want);
        endfunction

        function void cmp_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_pins(t_out_item got);
            t_out_item want;
            if (expected_pins.size() == 0) begin
                $error("pin result arrived with no request pending");
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            cmp_field("pin_data", want.pin_data, got.pin_data);
            cmp_field("pin_clock", want.pin_clock, got.pin_clock);
            cmp_field("pin_latch_enable", want.pin_latch_enable, got.pin_latch_enable);
            cmp_field("pin_read_mode", want.pin_read_mode, got.pin_read_mode);
            cmp_field("data_pin_driven", want.data_pin_driven, got.data_pin_driven);
            cmp_field("busy_res", want.busy_res, got.busy_res);
            cmp_field("read_valid", want.read_valid, got.read_valid);
            cmp_field("read_value", want.read_value, got.read_value);
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [TickW-1:0] cfg_data = '0;

    logic calm = 1'b0;
    int unsigned cycles = 0;
    pin_scoreboard board;

    three_wire_rf_serial_master i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5ns;
        clk = 1'b1;
        #5ns;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 32);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_pins(out_data);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_tick(input t_in_item it);
        while (!calm && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_tick(it);
    endtask

    // Runs the sequencer to idle with random content, including starts that must be ignored.
    task automatic finish_transfer(input int din_kind);
        t_in_item it;
        while (board.busy()) begin
            it.action = 2'($urandom_range(3));
            it.reg_addr = 5'($urandom);
            it.write_data = 12'($urandom);
            it.data_in = (din_kind == DIN_RANDOM) ? 1'($urandom) : (din_kind == DIN_HIGH);
            send_tick(it);
        end
    endtask

    task automatic run_op(input logic [1:0] act, input logic [4:0] addr,
                          input logic [11:0] wdata, input int din_kind);
        t_in_item it;
        it = '{action: act, reg_addr: addr, write_data: wdata, data_in: 1'b0};
        send_tick(it);
        finish_transfer(din_kind);
    endtask

    task automatic random_ticks(input int count);
        t_in_item it;
        int unsigned roll;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.pending() != 0) @(posedge clk);
            end
            roll = $urandom_range(99);
            if (roll < 6) begin
                it.action = ACT_WRITE;
            end else if (roll < 12) begin
                it.action = ACT_READ;
            end else if (roll < 16) begin
                it.action = ACT_UNUSED;
            end else begin
                it.action = ACT_PLAIN;
            end
            it.reg_addr = 5'($urandom);
            it.write_data = 12'($urandom);
            it.data_in = 1'($urandom);
            send_tick(it);
        end
        finish_transfer(DIN_RANDOM);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic configure(input logic [TickW-1:0] phase, input logic [TickW-1:0] settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_PHASE_TICKS, phase);
        write_reg(CFG_SETTLE_TICKS, settle);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        t_in_item it;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        it = '{action: ACT_UNUSED, reg_addr: 5'h1F, write_data: 12'hFFF, data_in: 1'b1};
        send_tick(it);
        send_tick(it);
        run_op(ACT_WRITE, 5'h1F, 12'hFFF, DIN_HIGH);
        run_op(ACT_WRITE, 5'h00, 12'h000, DIN_LOW);
        run_op(ACT_READ, 5'h1F, 12'hFFF, DIN_HIGH);
        run_op(ACT_READ, 5'h00, 12'h000, DIN_LOW);

        configure(10'd1, 10'd1);
        random_ticks(180);
        configure(10'd0, 10'd0);
        random_ticks(80);
        calm = 1'b1;
        configure(10'd3, 10'd2);
        random_ticks(100);
        calm = 1'b0;
        configure(10'd1, 10'd40);
        run_op(ACT_WRITE, 5'($urandom), 12'($urandom), DIN_RANDOM);
        configure(PHASE_TICKS_RST, SETTLE_TICKS_RST);
        random_ticks(100);

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
